// ===== src/scx_pkg.sv =====
// Shared widths and word types for the segment/circle intersection pipeline.
// No dependencies; every other file refers to this package by scoped names.
package scx_pkg;

   // Field widths
   localparam int COORD_WIDTH  = 32;
   localparam int T_FRAC_BITS  = 16;
   localparam int RADIUS_WIDTH = 31;
   localparam int RADIUS_RESET = 65536;

   // Derived arithmetic widths
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;              // dx, dy, fx, fy
   localparam int AREA_WIDTH = 2 * DIFF_WIDTH;               // a, |h|
   localparam int MAG_WIDTH  = (AREA_WIDTH > 2 * RADIUS_WIDTH) ?
                               AREA_WIDTH : 2 * RADIUS_WIDTH; // |c|
   localparam int HALF_WIDTH  = (MAG_WIDTH + 1) / 2;          // partial product operand
   localparam int SPLIT_WIDTH = 2 * HALF_WIDTH;
   localparam int SQ_WIDTH    = 2 * SPLIT_WIDTH;               // h*h, a*|c|
   localparam int RAD_WIDTH   = SQ_WIDTH + 4;                  // discriminant
   localparam int ROOT_WIDTH  = RAD_WIDTH / 2;
   localparam int B_WIDTH     = AREA_WIDTH + 2;
   localparam int DEN_WIDTH   = AREA_WIDTH + 1;
   localparam int REM_WIDTH   = DEN_WIDTH + 1;
   localparam int T_WIDTH     = T_FRAC_BITS + 1;

   // Front end to square root
   typedef struct packed {
      logic                 ok;
      logic [RAD_WIDTH-1:0] radicand;
      logic [B_WIDTH-1:0]   b;
      logic [DEN_WIDTH-1:0] den;
   } front_word_type;

   // Square root to divider
   typedef struct packed {
      logic                  ok;
      logic [ROOT_WIDTH-1:0] root;
      logic [B_WIDTH-1:0]    b;
      logic [DEN_WIDTH-1:0]  den;
   } root_word_type;

endpackage

// ===== src/scx_front.sv =====
// Front end: differences, products, quadratic coefficients and discriminant.
// Seven register stages. Depends on scx_pkg.
module scx_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]    start_x,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]    start_y,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]    end_x,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]    end_y,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]    center_x,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]    center_y,
   input  logic        [scx_pkg::RADIUS_WIDTH-1:0]   radius,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output scx_pkg::front_word_type                   out_word
);

   localparam int DW = scx_pkg::DIFF_WIDTH;
   localparam int AW = scx_pkg::AREA_WIDTH;
   localparam int MW = scx_pkg::MAG_WIDTH;
   localparam int HW = scx_pkg::HALF_WIDTH;
   localparam int SW = scx_pkg::SPLIT_WIDTH;
   localparam int SQ = scx_pkg::SQ_WIDTH;
   localparam int RW = scx_pkg::RADIUS_WIDTH;
   localparam int NS = 7;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] vin;
   logic [NS:0]   rdy;
   logic [NS-1:0] ld;

   // Stall chain: a stage takes a word when it is empty or its successor moves
   assign rdy[NS] = out_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = ~v_ff[i] | rdy[i+1];
   end
   assign vin      = {v_ff[NS-2:0], in_valid};
   assign ld       = vin & rdy[NS-1:0];
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~rdy[NS-1:0]) | (vin & rdy[NS-1:0]);
      end
   end

   // Stage 1: direction and offset vectors
   logic signed [DW-1:0] dx_in, dy_in, fx_in, fy_in;
   logic signed [DW-1:0] dx_ff, dy_ff, fx_ff, fy_ff;
   logic [RW-1:0]        r_ff;

   assign dx_in = DW'(end_x) - DW'(start_x);
   assign dy_in = DW'(end_y) - DW'(start_y);
   assign fx_in = DW'(start_x) - DW'(center_x);
   assign fy_in = DW'(start_y) - DW'(center_y);

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         r_ff  <= radius;
      end
   end

   // Stage 2: elementary products
   logic signed [AW-1:0] pxx_in, pyy_in, pfx_in, pfy_in, qxx_in, qyy_in;
   logic signed [AW-1:0] pxx_ff, pyy_ff, pfx_ff, pfy_ff, qxx_ff, qyy_ff;
   logic [2*RW-1:0]      r2_in, r2_ff;

   assign pxx_in = AW'(dx_ff) * AW'(dx_ff);
   assign pyy_in = AW'(dy_ff) * AW'(dy_ff);
   assign pfx_in = AW'(fx_ff) * AW'(dx_ff);
   assign pfy_in = AW'(fy_ff) * AW'(dy_ff);
   assign qxx_in = AW'(fx_ff) * AW'(fx_ff);
   assign qyy_in = AW'(fy_ff) * AW'(fy_ff);
   assign r2_in  = (2*RW)'(r_ff) * (2*RW)'(r_ff);

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         pxx_ff <= pxx_in;
         pyy_ff <= pyy_in;
         pfx_ff <= pfx_in;
         pfy_ff <= pfy_in;
         qxx_ff <= qxx_in;
         qyy_ff <= qyy_in;
         r2_ff  <= r2_in;
      end
   end

   // Stage 3: a = d.d, h = f.d, c = f.f - r*r
   logic [AW-1:0]        a3_in, a3_ff;
   logic signed [AW:0]   h3_in, h3_ff;
   logic signed [MW:0]   c3_in, c3_ff;

   assign a3_in = AW'(pxx_ff + pyy_ff);
   assign h3_in = (AW+1)'(pfx_ff) + (AW+1)'(pfy_ff);
   assign c3_in = $signed((MW+1)'(qxx_ff) + (MW+1)'(qyy_ff) - (MW+1)'(r2_ff));

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         a3_ff <= a3_in;
         h3_ff <= h3_in;
         c3_ff <= c3_in;
      end
   end

   // Stage 4: magnitudes for the split multiplies
   logic [SW-1:0]      hm4_in, cm4_in, hm4_ff, cm4_ff;
   logic [AW-1:0]      a4_ff;
   logic signed [AW:0] h4_ff;
   logic               cn4_ff;

   assign hm4_in = SW'(h3_ff[AW] ? -h3_ff : h3_ff);
   assign cm4_in = SW'(c3_ff[MW] ? -c3_ff : c3_ff);

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         hm4_ff <= hm4_in;
         cm4_ff <= cm4_in;
         a4_ff  <= a3_ff;
         h4_ff  <= h3_ff;
         cn4_ff <= c3_ff[MW];
      end
   end

   // Stage 5: half-width partial products of h*h and a*|c|
   logic [SW-1:0]      a_ext;
   logic [SW-1:0]      hh_in, hl_in, ll_in, ahch_in, ahcl_in, alch_in, alcl_in;
   logic [SW-1:0]      hh_ff, hl_ff, ll_ff, ahch_ff, ahcl_ff, alch_ff, alcl_ff;
   logic [AW-1:0]      a5_ff;
   logic signed [AW:0] h5_ff;
   logic               cn5_ff;

   assign a_ext   = SW'(a4_ff);
   assign hh_in   = SW'(hm4_ff[SW-1:HW]) * SW'(hm4_ff[SW-1:HW]);
   assign hl_in   = SW'(hm4_ff[SW-1:HW]) * SW'(hm4_ff[HW-1:0]);
   assign ll_in   = SW'(hm4_ff[HW-1:0])  * SW'(hm4_ff[HW-1:0]);
   assign ahch_in = SW'(a_ext[SW-1:HW])  * SW'(cm4_ff[SW-1:HW]);
   assign ahcl_in = SW'(a_ext[SW-1:HW])  * SW'(cm4_ff[HW-1:0]);
   assign alch_in = SW'(a_ext[HW-1:0])   * SW'(cm4_ff[SW-1:HW]);
   assign alcl_in = SW'(a_ext[HW-1:0])   * SW'(cm4_ff[HW-1:0]);

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         ahch_ff <= ahch_in;
         ahcl_ff <= ahcl_in;
         alch_ff <= alch_in;
         alcl_ff <= alcl_in;
         a5_ff   <= a4_ff;
         h5_ff   <= h4_ff;
         cn5_ff  <= cn4_ff;
      end
   end

   // Stage 6: assemble the full-width products
   logic [SQ-1:0]      hsq_in, ac_in, hsq_ff, ac_ff;
   logic [AW-1:0]      a6_ff;
   logic signed [AW:0] h6_ff;
   logic               cn6_ff;

   assign hsq_in = (SQ'(hh_ff) << (2*HW)) + (SQ'(hl_ff) << (HW+1)) + SQ'(ll_ff);
   assign ac_in  = (SQ'(ahch_ff) << (2*HW)) + ((SQ'(ahcl_ff) + SQ'(alch_ff)) << HW)
                 + SQ'(alcl_ff);

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         hsq_ff <= hsq_in;
         ac_ff  <= ac_in;
         a6_ff  <= a5_ff;
         h6_ff  <= h5_ff;
         cn6_ff <= cn5_ff;
      end
   end

   // Stage 7: quarter discriminant h*h - a*c, then disc = 4x that
   logic [SQ+1:0]           d_w;
   scx_pkg::front_word_type word_in, word_ff;

   assign d_w = cn6_ff ? (SQ+2)'(hsq_ff) + (SQ+2)'(ac_ff)
                       : (SQ+2)'(hsq_ff) - (SQ+2)'(ac_ff);

   always_comb begin
      word_in.ok       = (a6_ff != '0) && !d_w[SQ+1];
      word_in.radicand = {1'b0, d_w[SQ:0], 2'b00};
      word_in.b        = {h6_ff, 1'b0};
      word_in.den      = {a6_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (ld[6]) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_word  = word_ff;

endmodule

// ===== src/scx_sqrt.sv =====
// Floored square root of the discriminant, one root bit per register stage.
// Carries b and 2a alongside. Depends on scx_pkg.
module scx_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  scx_pkg::front_word_type in_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output scx_pkg::root_word_type  out_word
);

   localparam int RTW  = scx_pkg::ROOT_WIDTH;
   localparam int RSW  = RTW + 2;
   localparam int RADW = scx_pkg::RAD_WIDTH;
   localparam int BW   = scx_pkg::B_WIDTH;
   localparam int DNW  = scx_pkg::DEN_WIDTH;

   typedef struct packed {
      logic            ok;
      logic [RADW-1:0] radicand;
      logic [BW-1:0]   b;
      logic [DNW-1:0]  den;
      logic [RSW-1:0]  rem;
      logic [RTW-1:0]  root;
   } sqrt_step_type;

   logic [RTW-1:0] v_ff;
   logic [RTW-1:0] vin;
   logic [RTW:0]   rdy;
   logic [RTW-1:0] ld;
   sqrt_step_type  step_ff [RTW];

   // Stall chain
   assign rdy[RTW] = out_ready;
   for (genvar i = 0; i < RTW; i++) begin : g_rdy
      assign rdy[i] = ~v_ff[i] | rdy[i+1];
   end
   assign vin      = {v_ff[RTW-2:0], in_valid};
   assign ld       = vin & rdy[RTW-1:0];
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~rdy[RTW-1:0]) | (vin & rdy[RTW-1:0]);
      end
   end

   // Restoring digit-by-digit root: bring down two radicand bits, try root*4+1
   for (genvar i = 0; i < RTW; i++) begin : g_step
      localparam int P = 2 * (RTW - 1 - i);
      sqrt_step_type prev;
      sqrt_step_type step_in;
      logic [RSW-1:0] sh;
      logic [RSW-1:0] trial;

      if (i == 0) begin : g_first
         assign prev = '{ok: in_word.ok, radicand: in_word.radicand, b: in_word.b,
                         den: in_word.den, rem: '0, root: '0};
      end else begin : g_next
         assign prev = step_ff[i-1];
      end

      assign sh    = {prev.rem[RSW-3:0], prev.radicand[P+1:P]};
      assign trial = {prev.root, 2'b01};

      always_comb begin
         step_in = prev;
         if (sh >= trial) begin
            step_in.rem  = sh - trial;
            step_in.root = {prev.root[RTW-2:0], 1'b1};
         end else begin
            step_in.rem  = sh;
            step_in.root = {prev.root[RTW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ld[i]) begin
            step_ff[i] <= step_in;
         end
      end
   end

   assign out_valid     = v_ff[RTW-1];
   assign out_word.ok   = step_ff[RTW-1].ok;
   assign out_word.root = step_ff[RTW-1].root;
   assign out_word.b    = step_ff[RTW-1].b;
   assign out_word.den  = step_ff[RTW-1].den;

endmodule

// ===== src/scx_div.sv =====
// Root selection and the restoring divider that scales n / 2a to Q1.T_FRAC_BITS.
// One select stage, then one quotient bit per stage. Depends on scx_pkg.
module scx_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  scx_pkg::root_word_type              in_word,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic                                out_found,
   output logic [scx_pkg::T_WIDTH-1:0]         out_t
);

   localparam int RTW = scx_pkg::ROOT_WIDTH;
   localparam int BW  = scx_pkg::B_WIDTH;
   localparam int DNW = scx_pkg::DEN_WIDTH;
   localparam int RMW = scx_pkg::REM_WIDTH;
   localparam int TW  = scx_pkg::T_WIDTH;
   localparam int NW  = ((RTW > BW) ? RTW : BW) + 2;
   localparam int NS  = TW + 1;

   typedef struct packed {
      logic           found;
      logic [DNW-1:0] den;
      logic [RMW-1:0] rem;
      logic [TW-1:0]  q;
   } div_step_type;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] vin;
   logic [NS:0]   rdy;
   logic [NS-1:0] ld;
   div_step_type  step_ff [NS];

   // Stall chain
   assign rdy[NS] = out_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = ~v_ff[i] | rdy[i+1];
   end
   assign vin      = {v_ff[NS-2:0], in_valid};
   assign ld       = vin & rdy[NS-1:0];
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~rdy[NS-1:0]) | (vin & rdy[NS-1:0]);
      end
   end

   // Select: far root n2 = s - b first, near root n1 = -b - s as fallback
   logic signed [NW-1:0] s_w, b_w, den_w, n2, n1;
   logic                 in2, in1;
   div_step_type         sel_in;

   assign s_w   = $signed(NW'(in_word.root));
   assign b_w   = NW'($signed(in_word.b));
   assign den_w = $signed(NW'(in_word.den));
   assign n2    = s_w - b_w;
   assign n1    = -b_w - s_w;
   assign in2   = !n2[NW-1] && (n2 <= den_w);
   assign in1   = !n1[NW-1] && (n1 <= den_w);

   always_comb begin
      sel_in.found = in_word.ok && (in2 || in1);
      sel_in.den   = in_word.den;
      sel_in.q     = '0;
      priority if (in2) begin
         sel_in.rem = RMW'(n2[DNW-1:0]);
      end else if (in1) begin
         sel_in.rem = RMW'(n1[DNW-1:0]);
      end else begin
         sel_in.rem = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         step_ff[0] <= sel_in;
      end
   end

   // Quotient bits, most significant first; the top bit compares n itself
   for (genvar k = 0; k < TW; k++) begin : g_step
      div_step_type   prev;
      div_step_type   step_in;
      logic [RMW-1:0] sh;
      logic [RMW-1:0] den_x;
      logic           ge;

      assign prev = step_ff[k];
      if (k == 0) begin : g_first
         assign sh = prev.rem;
      end else begin : g_next
         assign sh = {prev.rem[RMW-2:0], 1'b0};
      end
      assign den_x = RMW'(prev.den);
      assign ge    = sh >= den_x;

      always_comb begin
         step_in     = prev;
         step_in.rem = ge ? sh - den_x : sh;
         step_in.q   = {prev.q[TW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (ld[k+1]) begin
            step_ff[k+1] <= step_in;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_found = step_ff[NS-1].found;
   assign out_t     = step_ff[NS-1].found ? step_ff[NS-1].q : '0;

endmodule

// ===== src/segment_circle_intersection_top.sv =====
// Segment/circle intersection: top level with the radius register and assertions.
// Uses scx_front, scx_sqrt, scx_div and scx_pkg.
//
//   channel  direction  handshake           word
//   req      in         req_valid/ready     segment ends and circle center
//   rsp      out        rsp_valid/ready     found flag and t_param
//   csr      in         csr_wr_en           lookahead radius (no wait)
//
// The pipeline holds seven front stages, one stage per root bit in the square
// root, one root select stage and one stage per quotient bit in the divider.
// One word is accepted every cycle unless a stalled output has backed the pipeline up to the
// input; each stage moves when it is empty or its successor moves, so bubbles close up under a stalled output.
// Synchronous reset empties the pipeline and sets the radius to 1.0.
module segment_circle_intersection_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]   req_start_x,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]   req_start_y,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]   req_end_x,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]   req_end_y,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]   req_center_x,
   input  logic signed [scx_pkg::COORD_WIDTH-1:0]   req_center_y,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_found,
   output logic [scx_pkg::T_WIDTH-1:0]              rsp_t_param,
   input  logic                                     csr_wr_en,
   input  logic [scx_pkg::RADIUS_WIDTH-1:0]         csr_wr_data
);

   localparam int RW = scx_pkg::RADIUS_WIDTH;

   logic [RW-1:0]           radius_ff;
   logic                    front_valid, front_ready;
   scx_pkg::front_word_type front_word;
   logic                    root_valid, root_ready;
   scx_pkg::root_word_type  root_word;

   // Radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RW'(scx_pkg::RADIUS_RESET);
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   scx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .center_x  (req_center_x),
      .center_y  (req_center_y),
      .radius    (radius_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_word  (front_word)
   );

   scx_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_word  (root_word)
   );

   scx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_ready  (root_ready),
      .in_word   (root_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_found (rsp_found),
      .out_t     (rsp_t_param)
   );

   // A miss always reports a zero parameter
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_t_param == '0))
      else $error("miss with nonzero t_param");

   // The parameter never exceeds 1.0
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_t_param <= (scx_pkg::T_WIDTH)'(1 << scx_pkg::T_FRAC_BITS)))
      else $error("t_param above 1.0");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // A word held at the output keeps its value until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found)
                                      && $stable(rsp_t_param)))
      else $error("stalled result word changed");

endmodule
